>>> src/longest_window_with_target_sum_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef LONGEST_WINDOW_WITH_TARGET_SUM_DEFINES_SVH
`define LONGEST_WINDOW_WITH_TARGET_SUM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LWTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LWTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lwts_pkg.sv
`timescale 1ns / 1ps
package lwts_pkg;

  // Fixed register field widths
  localparam int TARGET_W   = 26;
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  // Register byte addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = 2'd0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FETCH,
    ST_SUB,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // take the input value into the window
    logic check;    // compare window length with best length
    logic shrink;   // drop the oldest value from the window
    logic finish;   // load the result and clear the array state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gt;        // window sum above target and window not empty
    logic last;      // current value ends the array
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

>>> src/lwts_ctrl.sv
`timescale 1ns / 1ps
module lwts_ctrl import lwts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.gt) begin
          state_next = ST_FETCH;
        end else if (stat.last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: state_next = ST_SUB;
      ST_SUB:   state_next = ST_EVAL;
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EVAL:   cmd.check  = !stat.gt;
      ST_FETCH:  cmd        = '0;
      ST_SUB:    cmd.shrink = 1'b1;
      ST_FINISH: cmd.finish = stat.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

>>> src/lwts_datapath.sv
`timescale 1ns / 1ps
module lwts_datapath import lwts_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmd_t                              cmd,
  output stat_t                             stat,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic                              last,
  input  logic [TARGET_W-1:0]               target_sum,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] longest_length,
  output logic                              too_long
);

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int CMP_W  = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  logic [VALUE_BITS-1:0] window_store [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] rdata;

  logic [CNT_W-1:0] win_start;
  logic [CNT_W-1:0] win_end;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] best_len;
  logic             overflowed;
  logic             last_flag;

  logic             full;
  logic [CMP_W-1:0] sum_ext;
  logic [CMP_W-1:0] tgt_ext;
  logic [CNT_W-1:0] win_len;

  // Window status
  assign full    = (win_end == MAX_CNT);
  assign sum_ext = CMP_W'(win_sum);
  assign tgt_ext = CMP_W'(target_sum);
  assign win_len = win_end - win_start;

  assign stat.gt       = (sum_ext > tgt_ext) && (win_start < win_end);
  assign stat.last     = last_flag;
  assign stat.out_free = !out_valid || !out_stall;

  // Window store: write the new value, read the oldest one every cycle
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      window_store[win_end[ADDR_W-1:0]] <= value;
    end
    rdata <= window_store[win_start[ADDR_W-1:0]];
  end

  // Window counters, sum and best length
  always_ff @(posedge clk) begin
    if (rst) begin
      win_start  <= '0;
      win_end    <= '0;
      win_sum    <= '0;
      best_len   <= '0;
      overflowed <= 1'b0;
      last_flag  <= 1'b0;
    end else if (cmd.finish) begin
      win_start  <= '0;
      win_end    <= '0;
      win_sum    <= '0;
      best_len   <= '0;
      overflowed <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_flag <= last;
        if (full) begin
          overflowed <= 1'b1;
        end else begin
          win_end <= win_end + 1'b1;
          win_sum <= win_sum + SUM_W'(value);
        end
      end
      if (cmd.shrink) begin
        win_start <= win_start + 1'b1;
        win_sum   <= win_sum - SUM_W'(rdata);
      end
      if (cmd.check && (sum_ext == tgt_ext) && (win_len > best_len)) begin
        best_len <= win_len;
      end
    end
  end

  // Result register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      longest_length <= best_len;
      too_long       <= overflowed;
    end
  end

endmodule

>>> src/longest_window_with_target_sum.sv
`timescale 1ns / 1ps
// Channel   Signals                          Direction  Transaction when
// input     value, last, in_valid/in_stall   in         in_valid && !in_stall
// output    longest_length, too_long,        out        out_valid && !out_stall
//           out_valid/out_stall
// config    APB: psel penable pwrite paddr   in         psel && penable && pwrite
//           pwdata prdata pready
//
// An item that removes no value passes ST_IDLE and ST_EVAL; each value removed
// adds ST_FETCH, ST_SUB, ST_EVAL (store read, subtract, compare), set by the
// single registered read port of the window store. An item with last adds
// ST_FINISH to load the result, waiting there while a prior result is stalled.
// Reset is synchronous and clears the window, out_valid and target_sum.
module longest_window_with_target_sum import lwts_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] longest_length,
  output logic                              too_long,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [APB_ADDR_W-1:0]             paddr,
  input  logic [APB_DATA_W-1:0]             pwdata,
  output logic [APB_DATA_W-1:0]             prdata,
  output logic                              pready
);

  logic [TARGET_W-1:0] target_sum;
  cmd_t                cmd;
  stat_t               stat;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TARGET) ? APB_DATA_W'(target_sum) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_TARGET)) begin
      target_sum <= pwdata[TARGET_W-1:0];
    end
  end

  lwts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lwts_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .value          (value),
    .last           (last),
    .target_sum     (target_sum),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .longest_length (longest_length),
    .too_long       (too_long)
  );

endmodule

>>> src/lwts_checker.sv
`timescale 1ns / 1ps
`include "longest_window_with_target_sum_defines.svh"
module lwts_checker #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              last,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [$clog2(MAX_ELEMENTS+1)-1:0] longest_length,
  input logic                              too_long
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_ELEMENTS);

  logic           in_xfer;
  logic           mid_xfer;
  logic           out_held;
  logic [CNT_W:0] out_word;

  assign in_xfer  = in_valid && !in_stall;
  assign mid_xfer = in_xfer && !last;
  assign out_held = out_valid && out_stall;
  assign out_word = {longest_length, too_long};

  // Hold a stalled result
  `LWTS_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled result moved")

  // A result never reports more than the capacity
  `LWTS_ASSERT_NOW(a_len_range, out_valid, longest_length <= MAX_LEN, "length above capacity")

  // A value that does not end an array raises no result
  `LWTS_ASSERT_NEXT(a_no_early_result, mid_xfer, !$rose(out_valid), "result without last value")

endmodule

bind longest_window_with_target_sum lwts_checker #(
  .MAX_ELEMENTS (MAX_ELEMENTS),
  .VALUE_BITS   (VALUE_BITS)
) u_lwts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .last           (last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .longest_length (longest_length),
  .too_long       (too_long)
);
